[hdl/layered_viewport_compositor_defines.svh]
// Assertion helpers used by the compositor top module.
`ifndef LAYERED_VIEWPORT_COMPOSITOR_DEFINES_SVH
`define LAYERED_VIEWPORT_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define LVC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layered viewport compositor: same-cycle check failed");

// Next-cycle implication, held off while reset is high.
`define LVC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layered viewport compositor: next-cycle check failed");

`endif

[hdl/lvc_pkg.sv]
package lvc_pkg;

  // Item kinds carried on s_tuser
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FIELD_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LAYER_COUNT  = 3'd2;
  localparam logic [2:0] REG_TRANSPARENT  = 3'd3;
  localparam logic [2:0] REG_CLEAR_COLOR  = 3'd4;

  // Register reset values before clamping to the store geometry
  localparam int FIELD_WIDTH_RESET  = 128;
  localparam int FIELD_HEIGHT_RESET = 72;
  localparam int LAYER_COUNT_RESET  = 1;
  localparam logic [15:0] TRANSPARENT_RESET = 16'd0;
  localparam logic [15:0] CLEAR_COLOR_RESET = 16'd240;

  // Input tdata layout, lowest bit first
  localparam int IN_TDATA_W   = 96;
  localparam int OFS_INDEX    = 0;
  localparam int OFS_COLOR    = 16;
  localparam int OFS_STATIC   = 32;
  localparam int OFS_SCREEN_X = 33;
  localparam int OFS_SCREEN_Y = 42;
  localparam int OFS_ORIGIN_X = 51;
  localparam int OFS_ORIGIN_Y = 62;
  localparam int OFS_COLOR_IN = 73;

  // Shared multiply-add unit: p = a * b + c
  localparam int MAC_A_W = 16;
  localparam int MAC_B_W = 8;
  localparam int MAC_C_W = 24;
  localparam int MAC_P_W = 25;

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_WRITE  = 9'b000000100,
    ST_CANVAS = 9'b000001000,
    ST_LIMIT  = 9'b000010000,
    ST_CLEAR  = 9'b000100000,
    ST_BASE   = 9'b001000000,
    ST_LAYER  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } lvc_state_t;

  typedef struct packed {
    logic color_we;
    logic static_we;
    logic color_re;
    logic static_re;
  } lvc_store_ctrl_t;

endpackage

[hdl/lvc_mac.sv]
module lvc_mac import lvc_pkg::*; (
  input  logic [MAC_A_W-1:0] a,
  input  logic [MAC_B_W-1:0] b,
  input  logic [MAC_C_W-1:0] c,
  output logic [MAC_P_W-1:0] p
);

  logic [MAC_A_W+MAC_B_W-1:0] prod;

  assign prod = a * b;
  assign p    = MAC_P_W'(prod) + MAC_P_W'(c);

endmodule

[hdl/lvc_store.sv]
module lvc_store import lvc_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic            clk,
  input  lvc_store_ctrl_t ctrl,
  input  logic [AW-1:0]   waddr,
  input  logic [15:0]     color_wdata,
  input  logic            static_wdata,
  input  logic [AW-1:0]   raddr,
  output logic [15:0]     color_rdata,
  output logic            static_rdata
);

  logic [15:0] color_mem  [DEPTH];
  logic        static_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.color_we) begin
      color_mem[waddr] <= color_wdata;
    end
    if (ctrl.color_re) begin
      color_rdata <= color_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.static_we) begin
      static_mem[waddr] <= static_wdata;
    end
    if (ctrl.static_re) begin
      static_rdata <= static_mem[raddr];
    end
  end

endmodule

[hdl/layered_viewport_compositor.sv]
// Layer-priority compositor over a layered cell store of
// MAX_LAYERS*MAX_COLUMNS*MAX_ROWS cells (16-bit colour plus a static mark).
// Items arrive on s_axis with the kind in s_tuser: write one cell, clear all
// dynamic cells of the layers in use, or render one screen pixel; each gives
// one result on m_axis (colour in m_tdata, covered flag in m_tuser, zero for
// write and clear). One item is in work at a time and s_tready is low until
// its result is in the output register, which holds it while the next item is
// taken. A single 16x8 multiply-add unit, reused step by step, forms the canvas
// size, the clear extent, the pixel's cell offset and each layer's address.
// A render reads the store once per layer in use over the single read port, and
// an off-field render reads none; a clear checks one cell per cycle.
// After reset a sweep loads every cell with colour 240 and dynamic; no item is
// taken meanwhile, while configuration writes are taken at any time.
`include "layered_viewport_compositor_defines.svh"

module layered_viewport_compositor import lvc_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128,
  parameter int MAX_LAYERS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: cell_index[15:0], cell_color[31:16], cell_is_static[32],
  //        screen_x[41:33], screen_y[50:42], view_origin_x[61:51] (signed),
  //        view_origin_y[72:62] (signed), screen_color_in[88:73], zeros above
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // tuser: op[1:0]
  input  logic [1:0]            s_tuser,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: screen_color_out[15:0]
  output logic [15:0]           m_tdata,
  // tuser: covered[0]
  output logic                  m_tuser,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int DEPTH = MAX_LAYERS * MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW_RST = (FIELD_WIDTH_RESET > MAX_COLUMNS) ? MAX_COLUMNS : FIELD_WIDTH_RESET;
  localparam int FH_RST = (FIELD_HEIGHT_RESET > MAX_ROWS) ? MAX_ROWS : FIELD_HEIGHT_RESET;
  localparam int LC_RST = (LAYER_COUNT_RESET > MAX_LAYERS) ? MAX_LAYERS : LAYER_COUNT_RESET;

  // Clamp a size register: zero becomes one, anything above the limit the limit
  function automatic logic [7:0] clamp_size(input logic [7:0] v, input int hi);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) begin
      r = 8'd1;
    end else if (int'(v) > hi) begin
      r = 8'(hi);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [7:0]  field_width;
  logic [7:0]  field_height;
  logic [2:0]  layer_count;
  logic [15:0] transparent_color;
  logic [15:0] clear_color;
  logic [7:0]  lc_clamped;

  assign cfg_ready  = 1'b1;
  assign lc_clamped = clamp_size({5'd0, cfg_data[2:0]}, MAX_LAYERS);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width       <= 8'(FW_RST);
      field_height      <= 8'(FH_RST);
      layer_count       <= 3'(LC_RST);
      transparent_color <= TRANSPARENT_RESET;
      clear_color       <= CLEAR_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIELD_WIDTH:  field_width  <= clamp_size(cfg_data[7:0], MAX_COLUMNS);
        REG_FIELD_HEIGHT: field_height <= clamp_size(cfg_data[7:0], MAX_ROWS);
        REG_LAYER_COUNT:  layer_count  <= lc_clamped[2:0];
        REG_TRANSPARENT:  transparent_color <= cfg_data;
        REG_CLEAR_COLOR:  clear_color  <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  lvc_state_t state;

  // Latched item
  logic [1:0]         op_q;
  logic [15:0]        cell_index_q;
  logic [15:0]        cell_color_q;
  logic               cell_static_q;
  logic signed [11:0] fx_q;
  logic signed [11:0] fy_q;
  logic [15:0]        color_in_q;

  // Field position of the pixel: screen position plus the signed origin
  logic signed [11:0] fx_in;
  logic signed [11:0] fy_in;
  logic [10:0]        origin_x;
  logic [10:0]        origin_y;

  assign origin_x = s_tdata[OFS_ORIGIN_X +: 11];
  assign origin_y = s_tdata[OFS_ORIGIN_Y +: 11];
  assign fx_in = $signed({3'b000, s_tdata[OFS_SCREEN_X +: 9]}) + $signed({origin_x[10], origin_x});
  assign fy_in = $signed({3'b000, s_tdata[OFS_SCREEN_Y +: 9]}) + $signed({origin_y[10], origin_y});

  logic in_range;
  assign in_range = !fx_q[11] && (fx_q[10:0] < {3'b000, field_width}) &&
                    !fy_q[11] && (fy_q[10:0] < {3'b000, field_height});

  // Work registers
  logic [15:0]   canvas;
  logic [AW:0]   limit_q;
  logic [AW:0]   clr_idx;
  logic [AW-1:0] clr_addr;
  logic          clr_pend;
  logic [AW-1:0] init_idx;
  logic [AW-1:0] layer_addr;
  logic [2:0]    layer_idx;
  logic          rd_pend;
  logic [15:0]   result_color;
  logic          result_hit;
  logic          index_ok;

  assign index_ok = int'(cell_index_q) < DEPTH;

  // Shared multiply-add unit and its operand selection
  logic [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0] mac_b;
  logic [MAC_C_W-1:0] mac_c;
  logic [MAC_P_W-1:0] mac_p;

  always_comb begin
    mac_a = canvas;
    mac_b = MAC_B_W'(1);
    mac_c = MAC_C_W'(layer_addr);
    case (state)
      ST_CANVAS: begin
        mac_a = {8'd0, field_width};
        mac_b = field_height;
        mac_c = '0;
      end
      ST_LIMIT: begin
        mac_a = canvas;
        mac_b = {5'd0, layer_count};
        mac_c = '0;
      end
      ST_BASE: begin
        mac_a = {8'd0, fy_q[7:0]};
        mac_b = field_width;
        mac_c = MAC_C_W'(fx_q[7:0]);
      end
      default: ;  // layer walk: advance the address by one canvas
    endcase
  end

  lvc_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .p (mac_p)
  );

  // ---------------------------------------------------------------- store
  lvc_store_ctrl_t store_ctrl;
  logic [AW-1:0]   st_waddr;
  logic [15:0]     st_color_wdata;
  logic            st_static_wdata;
  logic [AW-1:0]   st_raddr;
  logic [15:0]     st_color_rdata;
  logic            st_static_rdata;
  logic            init_we;
  logic            wr_we;
  logic            clr_we;
  logic            layer_re;
  logic            clr_re;

  assign init_we  = (state == ST_INIT);
  assign wr_we    = (state == ST_WRITE) && index_ok;
  assign clr_we   = clr_pend && !st_static_rdata;
  assign layer_re = (state == ST_LAYER) && (layer_idx != layer_count);
  assign clr_re   = (state == ST_CLEAR) && (clr_idx != limit_q);

  always_comb begin
    store_ctrl.color_we  = init_we || wr_we || clr_we;
    store_ctrl.static_we = init_we || wr_we;
    store_ctrl.color_re  = layer_re;
    store_ctrl.static_re = clr_re;
    st_raddr = layer_re ? layer_addr : clr_idx[AW-1:0];
    if (init_we) begin
      st_waddr        = init_idx;
      st_color_wdata  = CLEAR_COLOR_RESET;
      st_static_wdata = 1'b0;
    end else if (wr_we) begin
      st_waddr        = AW'(cell_index_q);
      st_color_wdata  = cell_color_q;
      st_static_wdata = cell_static_q;
    end else begin
      st_waddr        = clr_addr;
      st_color_wdata  = clear_color;
      st_static_wdata = 1'b0;
    end
  end

  lvc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk          (clk),
    .ctrl         (store_ctrl),
    .waddr        (st_waddr),
    .color_wdata  (st_color_wdata),
    .static_wdata (st_static_wdata),
    .raddr        (st_raddr),
    .color_rdata  (st_color_rdata),
    .static_rdata (st_static_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  assign s_tready = (state == ST_IDLE);

  // Latch the item on acceptance
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q          <= s_tuser;
      cell_index_q  <= s_tdata[OFS_INDEX +: 16];
      cell_color_q  <= s_tdata[OFS_COLOR +: 16];
      cell_static_q <= s_tdata[OFS_STATIC];
      fx_q          <= fx_in;
      fy_q          <= fy_in;
      color_in_q    <= s_tdata[OFS_COLOR_IN +: 16];
    end
  end

  // Payload work registers: no reset needed
  always_ff @(posedge clk) begin
    clr_addr <= clr_idx[AW-1:0];
    case (state)
      ST_CANVAS: canvas <= mac_p[15:0];
      ST_LIMIT: begin
        limit_q <= (AW+1)'(mac_p);
      end
      ST_BASE:  layer_addr <= AW'(mac_p);
      ST_LAYER: begin
        if (layer_re) begin
          layer_addr <= AW'(mac_p);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      init_idx     <= '0;
      clr_idx      <= '0;
      clr_pend     <= 1'b0;
      layer_idx    <= '0;
      rd_pend      <= 1'b0;
      result_color <= '0;
      result_hit   <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      m_tuser      <= 1'b0;
    end else begin
      rd_pend  <= layer_re;
      clr_pend <= clr_re;

      // Last non-transparent layer wins; reads return in layer order
      if (rd_pend && (st_color_rdata != transparent_color)) begin
        result_color <= st_color_rdata;
        result_hit   <= 1'b1;
      end

      // Drop the output transaction once taken, unless a new result reloads it
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_INIT: begin
          init_idx <= init_idx + AW'(1);
          if (init_idx == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            result_color <= '0;
            result_hit   <= 1'b0;
            case (s_tuser)
              OP_WRITE:  state <= ST_WRITE;
              OP_CLEAR:  state <= ST_CANVAS;
              OP_RENDER: state <= ST_CANVAS;
              default:   state <= ST_EMIT;
            endcase
          end
        end
        ST_WRITE: state <= ST_EMIT;
        ST_CANVAS: begin
          state <= (op_q == OP_CLEAR) ? ST_LIMIT : ST_BASE;
        end
        ST_LIMIT: begin
          clr_idx <= '0;
          state   <= ST_CLEAR;
        end
        ST_CLEAR: begin
          if (clr_re) begin
            clr_idx <= clr_idx + (AW+1)'(1);
          end else if (!clr_pend) begin
            state <= ST_EMIT;
          end
        end
        ST_BASE: begin
          result_color <= color_in_q;
          layer_idx    <= '0;
          state        <= in_range ? ST_LAYER : ST_EMIT;
        end
        ST_LAYER: begin
          if (layer_re) begin
            layer_idx <= layer_idx + 3'd1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result_color;
            m_tuser  <= result_hit;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `LVC_ASSERT_IMP(a_no_accept_in_sweep, clk, rst, state == ST_INIT, !s_tready)
  `LVC_ASSERT_IMP(a_one_store_writer, clk, rst, 1'b1, $onehot0({init_we, wr_we, clr_we}))
  `LVC_ASSERT_IMP(a_ready_only_quiet, clk, rst, s_tready, !rd_pend && !clr_pend)
  `LVC_ASSERT_NEXT(a_emit_loads, clk, rst, state == ST_EMIT && (!m_tvalid || m_tready), m_tvalid && state == ST_IDLE)

endmodule
